>>> hw/rtl/integer_literal_parser_assert.svh
// assertion helpers for the integer literal parser
`ifndef INTEGER_LITERAL_PARSER_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_ASSERT_SVH

// generic clocked assertion with active-low reset
`define ILP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the block clock and reset
`define ILP_ASSERT_CLK(label, prop, msg) \
  `ILP_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

>>> hw/rtl/ilp_pkg.sv
`default_nettype none

package ilp_pkg;

  localparam int ILP_MAX_TOKEN_CHARS = 4096;
  localparam int ILP_VALUE_BITS      = 64;

  localparam int CP_W    = 21;
  localparam int RADIX_W = 6;
  localparam int OUT_W   = 64;

  localparam logic [RADIX_W-1:0] NO_DIGIT  = 6'd37;
  localparam logic [RADIX_W-1:0] BASE_MAX  = 6'd36;
  localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_BIN  = 6'd2;
  localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;

  localparam logic [CP_W-1:0] CH_PLUS  = 21'h2B;
  localparam logic [CP_W-1:0] CH_ZERO  = 21'h30;
  localparam logic [CP_W-1:0] CH_NINE  = 21'h39;
  localparam logic [CP_W-1:0] CH_UA    = 21'h41;
  localparam logic [CP_W-1:0] CH_UZ    = 21'h5A;
  localparam logic [CP_W-1:0] CH_LA    = 21'h61;
  localparam logic [CP_W-1:0] CH_LZ    = 21'h7A;
  localparam logic [CP_W-1:0] CH_LX    = 21'h78;
  localparam logic [CP_W-1:0] CH_UX    = 21'h58;
  localparam logic [CP_W-1:0] CH_LO    = 21'h6F;
  localparam logic [CP_W-1:0] CH_UO    = 21'h4F;
  localparam logic [CP_W-1:0] CH_LB    = 21'h62;
  localparam logic [CP_W-1:0] CH_UB    = 21'h42;
  localparam logic [CP_W-1:0] CH_SPACE = 21'h20;
  localparam logic [CP_W-1:0] CH_TAB   = 21'h09;
  localparam logic [CP_W-1:0] CH_CR    = 21'h0D;

  typedef enum logic [3:0] {
    PH_WS     = 4'd0,
    PH_WS2    = 4'd1,
    PH_ZERO_A = 4'd2,
    PH_ZEROS  = 4'd3,
    PH_ZERO_B = 4'd4,
    PH_PREFIX = 4'd5,
    PH_DIGITS = 4'd6,
    PH_STOP   = 4'd7,
    PH_OVF    = 4'd8
  } phase_e;

  typedef struct packed {
    phase_e               phase;
    logic [RADIX_W-1:0]   base;
    logic                 ovf;
    logic                 neg;
  } ctl_t;

  function automatic logic [RADIX_W-1:0] digit_value(input logic [CP_W-1:0] cp);
    logic [CP_W-1:0] t;
    t = {CP_W{1'b0}};
    if (cp >= CH_ZERO && cp <= CH_NINE) begin
      t = cp - CH_ZERO;
    end else if (cp >= CH_LA && cp <= CH_LZ) begin
      t = cp - CH_LA + 21'd10;
    end else if (cp >= CH_UA && cp <= CH_UZ) begin
      t = cp - CH_UA + 21'd10;
    end else begin
      t = CP_W'(NO_DIGIT);
    end
    return t[RADIX_W-1:0];
  endfunction

  function automatic logic is_space(input logic [CP_W-1:0] cp);
    return (cp == CH_SPACE) || (cp >= CH_TAB && cp <= CH_CR);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ilp_step.sv
`default_nettype none

// one character of parse: next state and the token result
module ilp_step #(
  parameter int MAX_TOKEN_CHARS = ilp_pkg::ILP_MAX_TOKEN_CHARS,
  parameter int VALUE_BITS      = ilp_pkg::ILP_VALUE_BITS,
  parameter int CHAR_W          = $clog2(MAX_TOKEN_CHARS + 1)
) (
  input  wire logic [ilp_pkg::RADIX_W-1:0] radix_i,
  input  wire logic [ilp_pkg::CP_W-1:0]    cp_i,
  input  wire logic                        neg_i,
  input  wire ilp_pkg::ctl_t               ctl_i,
  input  wire logic [VALUE_BITS-1:0]       acc_i,
  input  wire logic [CHAR_W-1:0]           idx_i,
  input  wire logic [CHAR_W-1:0]           end_i,
  output ilp_pkg::ctl_t                    ctl_o,
  output logic [VALUE_BITS-1:0]            acc_o,
  output logic [CHAR_W-1:0]                idx_o,
  output logic [CHAR_W-1:0]                end_o,
  output logic [ilp_pkg::OUT_W-1:0]        value_o,
  output logic [CHAR_W-1:0]                consumed_o,
  output logic                             whole_o,
  output logic                             rerr_o
);

  localparam logic [CHAR_W-1:0] IDX_MAX = CHAR_W'(MAX_TOKEN_CHARS);
  localparam int PROD_W = VALUE_BITS + 7;
  localparam logic [VALUE_BITS-1:0] SMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] SMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [ilp_pkg::RADIX_W-1:0] base_cur;
  logic [ilp_pkg::RADIX_W-1:0] d;
  logic                        is_zero;
  logic                        begin_num;
  logic                        do_take;
  logic                        bad_digit;
  logic [PROD_W-1:0]           prod;
  logic [VALUE_BITS-1:0]       v;

  assign d       = ilp_pkg::digit_value(cp_i);
  assign is_zero = (cp_i == ilp_pkg::CH_ZERO);
  // register and sign are taken on the first character
  assign base_cur = (idx_i == '0) ? radix_i : ctl_i.base;

  always_comb begin
    ctl_o       = ctl_i;
    ctl_o.base  = base_cur;
    ctl_o.neg   = (idx_i == '0) ? neg_i : ctl_i.neg;
    acc_o       = acc_i;
    end_o       = end_i;
    begin_num   = 1'b0;
    do_take     = 1'b0;
    bad_digit   = 1'b0;
    prod        = '0;

    case (ctl_i.phase)
      ilp_pkg::PH_WS: begin
        if (!ilp_pkg::is_space(cp_i)) begin
          if (cp_i == ilp_pkg::CH_PLUS) begin
            ctl_o.phase = ilp_pkg::PH_WS2;
          end else begin
            begin_num = 1'b1;
          end
        end
      end
      ilp_pkg::PH_WS2: begin
        begin_num = !ilp_pkg::is_space(cp_i);
      end
      ilp_pkg::PH_ZERO_A: begin
        if (cp_i == ilp_pkg::CH_LX || cp_i == ilp_pkg::CH_UX) begin
          ctl_o.base  = ilp_pkg::BASE_HEX;
          ctl_o.phase = ilp_pkg::PH_PREFIX;
          end_o       = idx_i;
        end else if (cp_i == ilp_pkg::CH_LO || cp_i == ilp_pkg::CH_UO) begin
          ctl_o.base  = ilp_pkg::BASE_OCT;
          ctl_o.phase = ilp_pkg::PH_PREFIX;
          end_o       = idx_i;
        end else if (cp_i == ilp_pkg::CH_LB || cp_i == ilp_pkg::CH_UB) begin
          ctl_o.base  = ilp_pkg::BASE_BIN;
          ctl_o.phase = ilp_pkg::PH_PREFIX;
          end_o       = idx_i;
        end else if (is_zero) begin
          ctl_o.phase = ilp_pkg::PH_ZEROS;
        end else begin
          ctl_o.phase = ilp_pkg::PH_STOP;
          end_o       = idx_i;
        end
      end
      ilp_pkg::PH_ZEROS: begin
        if (!is_zero) begin
          ctl_o.phase = ilp_pkg::PH_STOP;
          end_o       = idx_i;
        end
      end
      ilp_pkg::PH_ZERO_B: begin
        // optional prefix letter matching the fixed base
        if ((base_cur == ilp_pkg::BASE_HEX &&
             (cp_i == ilp_pkg::CH_LX || cp_i == ilp_pkg::CH_UX)) ||
            (base_cur == ilp_pkg::BASE_OCT &&
             (cp_i == ilp_pkg::CH_LO || cp_i == ilp_pkg::CH_UO)) ||
            (base_cur == ilp_pkg::BASE_BIN &&
             (cp_i == ilp_pkg::CH_LB || cp_i == ilp_pkg::CH_UB))) begin
          ctl_o.phase = ilp_pkg::PH_PREFIX;
          end_o       = idx_i;
        end else begin
          do_take = 1'b1;
        end
      end
      ilp_pkg::PH_PREFIX: begin
        if (d < base_cur) begin
          do_take = 1'b1;
        end else begin
          // parse ends at the prefix letter
          ctl_o.phase = ilp_pkg::PH_STOP;
        end
      end
      ilp_pkg::PH_DIGITS, ilp_pkg::PH_OVF: begin
        do_take = 1'b1;
      end
      default: begin
      end
    endcase

    if (begin_num) begin
      if (base_cur == ilp_pkg::BASE_AUTO) begin
        if (is_zero) begin
          ctl_o.phase = ilp_pkg::PH_ZERO_A;
        end else begin
          ctl_o.base = ilp_pkg::BASE_DEC;
          do_take    = 1'b1;
        end
      end else if (base_cur == ilp_pkg::BASE_HEX || base_cur == ilp_pkg::BASE_OCT ||
                   base_cur == ilp_pkg::BASE_BIN) begin
        if (is_zero) begin
          ctl_o.phase = ilp_pkg::PH_ZERO_B;
        end else begin
          do_take = 1'b1;
        end
      end else if (base_cur < ilp_pkg::BASE_BIN || base_cur > ilp_pkg::BASE_MAX) begin
        ctl_o.phase = ilp_pkg::PH_STOP;
        end_o       = idx_i;
      end else begin
        do_take = 1'b1;
      end
    end

    if (do_take) begin
      bad_digit = (ctl_o.base < ilp_pkg::BASE_BIN) || (ctl_o.base > ilp_pkg::BASE_MAX) ||
                  (d >= ctl_o.base);
      // multiply-add wide enough that any carry shows in the top bits
      prod = PROD_W'(acc_i) * PROD_W'(ctl_o.base) + PROD_W'(d);
      if (bad_digit) begin
        ctl_o.phase = ilp_pkg::PH_STOP;
        end_o       = idx_i;
      end else if (ctl_i.phase == ilp_pkg::PH_OVF) begin
        ctl_o.phase = ilp_pkg::PH_OVF;
      end else if (prod[PROD_W-1:VALUE_BITS] != '0) begin
        ctl_o.ovf   = 1'b1;
        ctl_o.phase = ilp_pkg::PH_OVF;
      end else begin
        acc_o       = prod[VALUE_BITS-1:0];
        ctl_o.phase = ilp_pkg::PH_DIGITS;
      end
    end
  end

  assign idx_o = (idx_i == IDX_MAX) ? idx_i : idx_i + CHAR_W'(1);

  always_comb begin
    if (ctl_o.phase == ilp_pkg::PH_STOP || ctl_o.phase == ilp_pkg::PH_PREFIX) begin
      consumed_o = end_o;
      whole_o    = 1'b0;
    end else begin
      consumed_o = idx_o;
      whole_o    = 1'b1;
    end

    rerr_o = 1'b0;
    if (ctl_o.ovf) begin
      v      = SMAX;
      rerr_o = 1'b1;
    end else if (!acc_o[VALUE_BITS-1]) begin
      v = ctl_o.neg ? ({VALUE_BITS{1'b0}} - acc_o) : acc_o;
    end else if (ctl_o.neg && acc_o == SMIN) begin
      v = SMIN;
    end else begin
      v      = SMAX;
      rerr_o = 1'b1;
    end
  end

  assign value_o = ilp_pkg::OUT_W'($signed(v));

endmodule

`default_nettype wire

>>> hw/rtl/integer_literal_parser.sv
// path: input register, combinational step, then output register holds the result
// throughput: one character per cycle unless a last item waits behind a held result,
//   set by the single accumulator multiply-add and overflow check between registers
// results: one per token, on the item with the last mark
// reset: asynchronous active low; parser returns to whitespace skip, radix to 0
`default_nettype none

module integer_literal_parser #(
  parameter int MAX_TOKEN_CHARS = ilp_pkg::ILP_MAX_TOKEN_CHARS,
  parameter int VALUE_BITS      = ilp_pkg::ILP_VALUE_BITS,
  parameter int CHAR_W          = $clog2(MAX_TOKEN_CHARS + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [ilp_pkg::RADIX_W-1:0] cfg_wdata_i,
  // input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [ilp_pkg::CP_W-1:0]    code_point_i,
  input  wire logic                        negate_i,
  input  wire logic                        last_char_i,
  // output channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [ilp_pkg::OUT_W-1:0]        value_o,
  output logic [CHAR_W-1:0]                chars_consumed_o,
  output logic                             whole_token_o,
  output logic                             range_error_o
);

  // radix register
  logic [ilp_pkg::RADIX_W-1:0] radix_q;

  // input register
  logic                     in_valid_q;
  logic [ilp_pkg::CP_W-1:0] cp_q;
  logic                     neg_q;
  logic                     last_q;

  // parser state
  ilp_pkg::ctl_t         ctl_q, ctl_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [CHAR_W-1:0]     idx_q, idx_d;
  logic [CHAR_W-1:0]     end_q, end_d;

  // step results
  logic [ilp_pkg::OUT_W-1:0] value_d;
  logic [CHAR_W-1:0]         consumed_d;
  logic                      whole_d;
  logic                      rerr_d;

  // output register
  logic                      out_valid_q;
  logic [ilp_pkg::OUT_W-1:0] value_q;
  logic [CHAR_W-1:0]         consumed_q;
  logic                      whole_q;
  logic                      rerr_q;

  logic in_accept;
  logic consume;
  logic emit;

  // the buffered item moves on unless it carries a result and the output
  // register is full and held
  assign consume    = in_valid_q && (!last_q || !out_valid_q || !out_stall_i);
  assign emit       = consume && last_q;
  assign in_stall_o = in_valid_q && !consume;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= ilp_pkg::BASE_AUTO;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cp_q   <= code_point_i;
      neg_q  <= negate_i;
      last_q <= last_char_i;
    end
  end

  ilp_step #(
    .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS),
    .VALUE_BITS     (VALUE_BITS),
    .CHAR_W         (CHAR_W)
  ) u_step (
    .radix_i   (radix_q),
    .cp_i      (cp_q),
    .neg_i     (neg_q),
    .ctl_i     (ctl_q),
    .acc_i     (acc_q),
    .idx_i     (idx_q),
    .end_i     (end_q),
    .ctl_o     (ctl_d),
    .acc_o     (acc_d),
    .idx_o     (idx_d),
    .end_o     (end_d),
    .value_o   (value_d),
    .consumed_o(consumed_d),
    .whole_o   (whole_d),
    .rerr_o    (rerr_d)
  );

  // parser state clears after each token's last item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{phase: ilp_pkg::PH_WS, base: ilp_pkg::BASE_AUTO, ovf: 1'b0, neg: 1'b0};
      acc_q <= '0;
      idx_q <= '0;
      end_q <= '0;
    end else if (consume) begin
      if (last_q) begin
        ctl_q <= '{phase: ilp_pkg::PH_WS, base: ilp_pkg::BASE_AUTO, ovf: 1'b0, neg: 1'b0};
        acc_q <= '0;
        idx_q <= '0;
        end_q <= '0;
      end else begin
        ctl_q <= ctl_d;
        acc_q <= acc_d;
        idx_q <= idx_d;
        end_q <= end_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      value_q    <= value_d;
      consumed_q <= consumed_d;
      whole_q    <= whole_d;
      rerr_q     <= rerr_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign value_o          = value_q;
  assign chars_consumed_o = consumed_q;
  assign whole_token_o    = whole_q;
  assign range_error_o    = rerr_q;

endmodule

`default_nettype wire

>>> hw/rtl/ilp_checker.sv
`default_nettype none
`include "integer_literal_parser_assert.svh"

module ilp_checker #(
  parameter int VALUE_BITS = ilp_pkg::ILP_VALUE_BITS,
  parameter int CHAR_W     = 13
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [ilp_pkg::OUT_W-1:0]   value_o,
  input wire logic [CHAR_W-1:0]           chars_consumed_o,
  input wire logic                        range_error_o
);

  localparam logic [ilp_pkg::OUT_W-1:0] SAT_MAX =
    ilp_pkg::OUT_W'({1'b0, {(VALUE_BITS-1){1'b1}}});

  // a held result keeps its value and length
  `ILP_ASSERT_CLK(a_out_hold,
    $past(out_valid_o && out_stall_i) |-> out_valid_o && $stable(value_o) &&
    $stable(chars_consumed_o), "result changed while stalled")

  // input only backs up behind a held result
  `ILP_ASSERT_CLK(a_stall_cause,
    in_stall_o |-> out_valid_o && out_stall_i, "input stalled without output backpressure")

  // an out-of-range magnitude saturates to the largest signed value
  `ILP_ASSERT_CLK(a_range_sat,
    out_valid_o && range_error_o |-> value_o == SAT_MAX, "range error without saturation")

endmodule

bind integer_literal_parser ilp_checker #(
  .VALUE_BITS(VALUE_BITS),
  .CHAR_W    (CHAR_W)
) u_ilp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .value_o         (value_o),
  .chars_consumed_o(chars_consumed_o),
  .range_error_o   (range_error_o)
);

`default_nettype wire
